[sv/tmma_pkg.sv]
// Shared types and constants for the tile matrix multiply-accumulate block.
`default_nettype none
package tmma_pkg;

    localparam int OP_W   = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 48;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Tile command passed from the loader to the compute engine.
    typedef struct packed {
        logic bank;
        logic final_flag;
    } cmd_t;

    // Operand store write from the loader.
    typedef struct packed {
        logic                   en;
        logic                   bank;
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
    } wr_t;

    // Operand bank handed back by the compute engine.
    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

endpackage
`default_nettype wire

[sv/tmma_front.sv]
// Loader: takes input words, fills the free operand bank, issues tile commands.
`default_nettype none
module tmma_front
    import tmma_pkg::*;
#(
    parameter int TILE = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [OP_W-1:0] a_elem,
    input  wire logic signed [OP_W-1:0] b_elem,
    input  wire logic                   final_block,
    output wr_t                         wr,
    output logic [$clog2(TILE*TILE)-1:0] wr_addr,
    output logic                        push_valid,
    input  wire logic                   push_ready,
    output cmd_t                        push_cmd,
    input  wire rel_t                   rel
);

    localparam int ELEMS = TILE * TILE;
    localparam int IDX_W = $clog2(ELEMS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMS - 1);

    logic [IDX_W-1:0] count_reg, count_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic             accept;
    logic             tile_done;

    assign in_ready  = !busy_reg[bank_reg] && push_ready;
    assign accept    = in_valid && in_ready;
    assign tile_done = accept && (count_reg == LAST_IDX);

    assign wr.en   = accept;
    assign wr.bank = bank_reg;
    assign wr.a    = a_elem;
    assign wr.b    = b_elem;
    assign wr_addr = count_reg;

    assign push_valid          = tile_done;
    assign push_cmd.bank       = bank_reg;
    assign push_cmd.final_flag = final_block;

    always_comb
    begin
        count_next = count_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        if (rel.en)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            if (tile_done)
            begin
                count_next          = '0;
                bank_next           = !bank_reg;
                busy_next[bank_reg] = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule
`default_nettype wire

[sv/tmma_cmdq.sv]
// Two-entry command queue between loader and compute engine.
`default_nettype none
module tmma_cmdq
    import tmma_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] fill_reg;
    logic       do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_cmd    = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[sv/tmma_back.sv]
// Compute engine: operand and accumulator stores, shared MAC, result register.
`default_nettype none
module tmma_back
    import tmma_pkg::*;
#(
    parameter int TILE = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire wr_t                     wr,
    input  wire logic [$clog2(TILE*TILE)-1:0] wr_addr,
    input  wire logic                    cmd_valid,
    output logic                         cmd_ready,
    input  wire cmd_t                    cmd,
    output rel_t                         rel,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [ACC_W-1:0]      c_elem,
    output logic                         last
);

    localparam int ELEMS = TILE * TILE;
    localparam int IDX_W = $clog2(ELEMS);
    localparam int BANK_DEPTH = 2 ** IDX_W;
    localparam int T_W   = $clog2(TILE);
    localparam int SUM_W = PROD_W + $clog2(TILE);
    localparam int WIDE_W = ACC_W + 2;
    localparam logic [IDX_W-1:0] TILE_IDX = IDX_W'(TILE);
    localparam logic [T_W-1:0]   T_LAST   = T_W'(TILE - 1);
    localparam logic signed [WIDE_W-1:0] WIDE_MAX = {2'b00, ACC_MAX};
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = {2'b11, ACC_MIN};

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_WB
    } state_t;

    // operand stores, two banks each
    logic signed [OP_W-1:0] left_mem  [2*BANK_DEPTH];
    logic signed [OP_W-1:0] right_mem [2*BANK_DEPTH];
    logic signed [ACC_W-1:0] acc_mem  [ELEMS];

    state_t st_reg;
    logic             bank_reg, final_reg;
    logic [T_W-1:0]   i_reg, j_reg, k_reg;
    logic [ELEMS-1:0] acc_vld_reg;
    logic             p1_vld_reg, p2_vld_reg;
    logic signed [OP_W-1:0]   a_q_reg, b_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  acc_q_reg;
    logic             acc_hit_reg;
    logic             out_vld_reg, last_reg;
    logic signed [ACC_W-1:0]  c_reg;

    logic             rd_issue, acc_rd;
    logic [IDX_W-1:0] a_idx, b_idx, c_idx;
    logic signed [ACC_W-1:0]  acc_val;
    logic signed [WIDE_W-1:0] wide_sum;
    logic signed [ACC_W-1:0]  sat_val;
    logic             slot_free, wb_go, acc_wr;
    logic             last_elem;

    assign a_idx = IDX_W'(i_reg) * TILE_IDX + IDX_W'(k_reg);
    assign b_idx = IDX_W'(k_reg) * TILE_IDX + IDX_W'(j_reg);
    assign c_idx = IDX_W'(i_reg) * TILE_IDX + IDX_W'(j_reg);

    assign rd_issue = (st_reg == S_RUN);
    assign acc_rd   = rd_issue && (k_reg == '0);

    assign acc_val  = acc_hit_reg ? acc_q_reg : '0;
    assign wide_sum = {{2{acc_val[ACC_W-1]}}, acc_val}
                    + {{(WIDE_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};

    always_comb
    begin
        if (wide_sum > WIDE_MAX)
        begin
            sat_val = ACC_MAX;
        end
        else if (wide_sum < WIDE_MIN)
        begin
            sat_val = ACC_MIN;
        end
        else
        begin
            sat_val = wide_sum[ACC_W-1:0];
        end
    end

    assign slot_free = !out_vld_reg || out_ready;
    assign wb_go     = (st_reg == S_WB) && (!final_reg || slot_free);
    assign acc_wr    = wb_go && !final_reg;
    assign last_elem = (i_reg == T_LAST) && (j_reg == T_LAST);

    assign cmd_ready = (st_reg == S_IDLE);
    assign rel.en    = wb_go && last_elem;
    assign rel.bank  = bank_reg;

    assign out_valid = out_vld_reg;
    assign c_elem    = c_reg;
    assign last      = last_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            left_mem[{wr.bank, wr_addr}]  <= wr.a;
            right_mem[{wr.bank, wr_addr}] <= wr.b;
        end
        if (rd_issue)
        begin
            a_q_reg <= left_mem[{bank_reg, a_idx}];
            b_q_reg <= right_mem[{bank_reg, b_idx}];
        end
        if (acc_wr)
        begin
            acc_mem[c_idx] <= sat_val;
        end
        if (acc_rd)
        begin
            acc_q_reg <= acc_mem[c_idx];
        end
    end

    // datapath without reset
    always_ff @(posedge clk)
    begin
        prod_reg <= a_q_reg * b_q_reg;
        if (cmd_valid && cmd_ready)
        begin
            sum_reg <= '0;
        end
        else if (wb_go)
        begin
            sum_reg <= '0;
        end
        else if (p2_vld_reg)
        begin
            sum_reg <= sum_reg + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (acc_rd)
        begin
            acc_hit_reg <= acc_vld_reg[c_idx];
        end
        if (wb_go && final_reg)
        begin
            c_reg    <= sat_val;
            last_reg <= last_elem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_IDLE;
            bank_reg    <= 1'b0;
            final_reg   <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            acc_vld_reg <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= rd_issue;
            p2_vld_reg <= p1_vld_reg;
            if (wb_go && final_reg)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_vld_reg && out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        bank_reg  <= cmd.bank;
                        final_reg <= cmd.final_flag;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        st_reg    <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (k_reg == T_LAST)
                    begin
                        k_reg  <= '0;
                        st_reg <= S_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    // last product lands in the sum on this edge
                    if (!p1_vld_reg)
                    begin
                        st_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (wb_go)
                    begin
                        if (final_reg)
                        begin
                            acc_vld_reg[c_idx] <= 1'b0;
                        end
                        else
                        begin
                            acc_vld_reg[c_idx] <= 1'b1;
                        end
                        if (j_reg == T_LAST)
                        begin
                            j_reg <= '0;
                            if (i_reg == T_LAST)
                            begin
                                st_reg <= S_IDLE;
                            end
                            else
                            begin
                                i_reg  <= i_reg + 1'b1;
                                st_reg <= S_RUN;
                            end
                        end
                        else
                        begin
                            j_reg  <= j_reg + 1'b1;
                            st_reg <= S_RUN;
                        end
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/tile_matrix_multiply_accumulate.sv]
// Top level of the tile matrix multiply-accumulate block.
// Schedule: one shared MAC serves every C element in turn; for each it steps k through TILE
//   operand pairs in S_RUN, drains the product pipeline in S_DRAIN, then writes back in S_WB.
// Output: a final tile's C words come from the result register in row-major order; S_WB of a
//   final tile waits while the result register is full and out_ready is low.
// Reset: control, queue and bank ownership cleared; accumulator entries read zero via valid bits.
`default_nettype none
module tile_matrix_multiply_accumulate
    import tmma_pkg::*;
#(
    parameter int TILE = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [OP_W-1:0]  a_elem,
    input  wire logic signed [OP_W-1:0]  b_elem,
    input  wire logic                    final_block,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [ACC_W-1:0]      c_elem,
    output logic                         last
);

    // Front: each word is written straight into the operand bank being filled
    // (two banks, ping-pong). The word that completes a tile pair pushes a
    // command carrying the bank and the final flag; the flag on any other word
    // is dropped. A bank stays owned by the engine until its tile is done, so
    // the next tile loads while the current one computes.
    //
    // Back: for each C element in row-major order, TILE reads of A row and
    // B column feed a registered 16x16 multiply and a running sum. The sum is
    // added to the accumulator entry with 48-bit saturation. A plain tile
    // writes the accumulator; a final tile sends the value to the result
    // register and invalidates the entry, which clears it.

    localparam int IDX_W = $clog2(TILE * TILE);

    wr_t              wr;
    logic [IDX_W-1:0] wr_addr;
    logic             push_valid, push_ready;
    cmd_t             push_cmd;
    logic             cmd_valid, cmd_ready;
    cmd_t             cmd;
    rel_t             rel;

    tmma_front #(
        .TILE (TILE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .a_elem      (a_elem),
        .b_elem      (b_elem),
        .final_block (final_block),
        .wr          (wr),
        .wr_addr     (wr_addr),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd),
        .rel         (rel)
    );

    tmma_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_cmd    (cmd)
    );

    tmma_back #(
        .TILE (TILE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rel       (rel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .c_elem    (c_elem),
        .last      (last)
    );

endmodule
`default_nettype wire

[tb/testbench.sv]
// Testbench for the tile matrix multiply-accumulate block: operand words in, C words checked.
module testbench
    import tmma_pkg::*;
();

    localparam int TILE         = 8;
    localparam int TILE_WORDS   = TILE * TILE;
    localparam int RAND_TILES   = 2;
    // No handshake at all for this long means the block is stuck. A busy engine
    // with both banks full can hold in_ready low for a whole tile compute.
    localparam int IDLE_LIMIT   = 8000;
    // Quiet time after the last C word, to catch stray results.
    localparam int DRAIN_CYCLES = 8 * (TILE + 4);

    // Operand fill patterns for one tile pair.
    typedef enum int {
        FILL_MAX_PRODUCT,   // every operand -1.0, largest positive products
        FILL_EDGES,         // walk through the edge values in a fixed order
        FILL_FULL_RANGE,    // uniform over the whole 16-bit range
        FILL_CORNERS,       // random picks among the edge values
        FILL_SMALL          // small signed values near zero
    } fill_t;

    // Receiver stall behavior; switched at random over the run.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_LONG
    } rx_mode_t;

    typedef struct {
        logic signed [OP_W-1:0] a;
        logic signed [OP_W-1:0] b;
        logic                   fb;
        logic                   hold;   // hold off until every C word has drained
    } operand_word_t;

    typedef struct {
        logic signed [ACC_W-1:0] c;
        logic                    last;
    } c_word_t;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic signed [OP_W-1:0]  a_elem      = '0;
    logic signed [OP_W-1:0]  b_elem      = '0;
    logic                    final_block = 1'b0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic signed [ACC_W-1:0] c_elem;
    logic                    last;

    tile_matrix_multiply_accumulate #(
        .TILE(TILE)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .a_elem     (a_elem),
        .b_elem     (b_elem),
        .final_block(final_block),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .c_elem     (c_elem),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tile product predictor: own copy of both operand tiles, the
    // accumulator tile and the load index.
    // ------------------------------------------------------------------
    logic signed [OP_W-1:0]  left_op  [TILE_WORDS];
    logic signed [OP_W-1:0]  right_op [TILE_WORDS];
    logic signed [ACC_W-1:0] acc_c    [TILE_WORDS];
    int unsigned             load_idx = 0;

    c_word_t       c_expected[$];   // C words still owed by the block, oldest first
    operand_word_t word_q[$];       // operand words not yet driven

    int words_accepted = 0;
    int c_checked      = 0;
    int tiles_emitted  = 0;
    int error_count    = 0;
    int idle_cycles    = 0;
    int total_words;
    logic in_fire = 1'b0;           // input handshake seen at the last rising edge

    // Store one operand pair; on the last pair of a tile fold A*B into the
    // accumulator, and on a flagged last pair emit and clear the whole tile.
    task automatic load_operand_word(input operand_word_t w);
        longint  dot;
        longint  sum;
        int      i;
        int      j;
        int      k;
        c_word_t cw;
        left_op[load_idx]  = w.a;
        right_op[load_idx] = w.b;
        if (load_idx < TILE_WORDS - 1)
        begin
            load_idx++;
        end
        else
        begin
            load_idx = 0;
            for (i = 0; i < TILE; i++)
            begin
                for (j = 0; j < TILE; j++)
                begin
                    // exact dot product of Q2.30 products, saturation only after the add
                    dot = 0;
                    for (k = 0; k < TILE; k++)
                        dot += left_op[i*TILE + k] * right_op[k*TILE + j];
                    sum = acc_c[i*TILE + j] + dot;
                    if (sum > ACC_MAX)
                        sum = ACC_MAX;
                    else if (sum < ACC_MIN)
                        sum = ACC_MIN;
                    acc_c[i*TILE + j] = sum[ACC_W-1:0];
                end
            end
            // flag counts only on the word that completes the tile
            if (w.fb)
            begin
                for (i = 0; i < TILE_WORDS; i++)
                begin
                    cw.c    = acc_c[i];
                    cw.last = (i == TILE_WORDS - 1);
                    c_expected.push_back(cw);
                    acc_c[i] = '0;
                end
                tiles_emitted++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic logic signed [OP_W-1:0] edge_operand(input int sel);
        case (sel % 5)
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'sh0001;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Queue one full tile pair. stray_flags sets final_block on words that do
    // not complete the tile, which the block must ignore.
    task automatic queue_tile(input fill_t fill, input logic stray_flags,
                              input logic fb_last, input logic hold_first);
        operand_word_t w;
        int            n;
        for (n = 0; n < TILE_WORDS; n++)
        begin
            case (fill)
                FILL_MAX_PRODUCT:
                begin
                    w.a = 16'sh8000;
                    w.b = 16'sh8000;
                end
                FILL_EDGES:
                begin
                    w.a = edge_operand(n);
                    w.b = edge_operand(3*n + 1);
                end
                FILL_CORNERS:
                begin
                    w.a = edge_operand($urandom_range(0, 4));
                    w.b = edge_operand($urandom_range(0, 4));
                end
                FILL_SMALL:
                begin
                    w.a = OP_W'(int'($urandom_range(0, 16)) - 8);
                    w.b = OP_W'(int'($urandom_range(0, 16)) - 8);
                end
                default:
                begin
                    w.a = OP_W'($urandom_range(0, 16'hFFFF));
                    w.b = OP_W'($urandom_range(0, 16'hFFFF));
                end
            endcase
            if (n == TILE_WORDS - 1)
                w.fb = fb_last;
            else
                w.fb = stray_flags && ($urandom_range(0, 2) == 0);
            w.hold = hold_first && (n == 0);
            word_q.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: operand words and out_ready change on the falling edge.
    // Sender runs in bursts with gaps; receiver stalls per rx mode.
    // ------------------------------------------------------------------
    int       burst_left    = 1;
    int       gap_left      = 0;
    int       mode_left     = 0;
    int       stall_left    = 0;
    rx_mode_t rx_mode       = RX_ALWAYS;
    logic [15:0] ready_pattern = 16'hFFFF;

    always @(negedge clk)
    begin
        operand_word_t nxt;
        if (rst_n)
        begin
            // a presented word stays put until the handshake
            if (!in_valid || in_fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_q.size() > 0 && !(word_q[0].hold && c_expected.size() > 0))
                begin
                    nxt = word_q.pop_front();
                    a_elem      <= nxt.a;
                    b_elem      <= nxt.b;
                    final_block <= nxt.fb;
                    in_valid    <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        // a quarter of the bursts run straight into the next one
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end

            if (mode_left == 0)
            begin
                rx_mode       = rx_mode_t'($urandom_range(0, 3));
                mode_left     = $urandom_range(20, 200);
                ready_pattern = 16'($urandom_range(1, 16'hFFFF));
            end
            else
            begin
                mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS:
                    out_ready <= 1'b1;
                RX_RANDOM:
                    out_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN:
                begin
                    ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
                    out_ready <= ready_pattern[0];
                end
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        out_ready <= 1'b1;
                        if ($urandom_range(0, 9) == 0)
                            stall_left = $urandom_range(5, 30);
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: handshakes sampled on the rising edge. Accepted operand
    // words feed the predictor; accepted C words are checked in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        operand_word_t seen;
        c_word_t       want;
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (in_valid && in_ready)
            begin
                seen.a    = a_elem;
                seen.b    = b_elem;
                seen.fb   = final_block;
                seen.hold = 1'b0;
                load_operand_word(seen);
                words_accepted <= words_accepted + 1;
            end

            if (out_valid && out_ready)
            begin
                c_checked <= c_checked + 1;
                if (c_expected.size() == 0)
                begin
                    $error("C word with none expected: c_elem %0d last %0b", c_elem, last);
                    error_count++;
                end
                else
                begin
                    want = c_expected.pop_front();
                    if (c_elem !== want.c)
                    begin
                        $error("c_elem: expected %0d, got %0d", want.c, c_elem);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int    t;
        int    e;
        fill_t fill;
        for (e = 0; e < TILE_WORDS; e++)
            acc_c[e] = '0;

        // Directed: a tile of largest products, stray flags, no final flag
        // (accumulate only); then edge operands closed with the flag, so the
        // emitted tile holds both.
        queue_tile(FILL_MAX_PRODUCT, 1'b1, 1'b0, 1'b0);
        queue_tile(FILL_EDGES, 1'b0, 1'b1, 1'b0);

        // Random tile pairs. The first waits until the directed tile has fully
        // drained; the last one emits so nothing stays in the accumulator.
        for (t = 0; t < RAND_TILES; t++)
        begin
            case ($urandom_range(0, 3))
                0:       fill = FILL_CORNERS;
                1:       fill = FILL_SMALL;
                default: fill = FILL_FULL_RANGE;
            endcase
            queue_tile(fill, 1'b1,
                       (t == RAND_TILES - 1) ? 1'b1 : 1'($urandom_range(0, 1)),
                       t == 0);
        end
        total_words = word_q.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_accepted < total_words)
            @(posedge clk);
        while (c_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d operand words in %0d tile pairs; %0d C tiles emitted, %0d C words checked",
                 words_accepted, words_accepted / TILE_WORDS, tiles_emitted, c_checked);
        $display("covered edge and random operands, ignored stray flags, bursty sender, stalls");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
